// ----- sv/key_value_table_macros.svh -----
// ----------------------------------------------------------------------------
// key_value_table_macros
// assertion macros used by the key value table rtl
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define KVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// shared types and codes of the key value table
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KVT_CAPACITY = 16;
    localparam int KVT_KEY_W    = 32;
    localparam int KVT_VAL_W    = 32;
    localparam int KVT_OP_W     = 2;
    localparam int KVT_ST_W     = 2;

    // opcodes
    localparam logic [KVT_OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [KVT_OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [KVT_OP_W-1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [KVT_ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [KVT_ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [KVT_ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [KVT_ST_W-1:0] ST_FULL      = 2'd3;

    // request token walking down the cell row
    typedef struct packed {
        logic [KVT_OP_W-1:0]         opcode;
        logic signed [KVT_KEY_W-1:0] key;
        logic signed [KVT_VAL_W-1:0] value;
        logic                        match;
        logic                        free_seen;
        logic                        any_valid;
        logic signed [KVT_VAL_W-1:0] rd;
    } t_token;

    // end-of-row commit broadcast for a reserved free entry
    typedef struct packed {
        logic valid;
        logic commit;
    } t_commit;

endpackage

// ----- sv/kvt_cell.sv -----
// ----------------------------------------------------------------------------
// kvt_cell
// one table entry; compares the passing token and hands it to the next cell
// ----------------------------------------------------------------------------
module kvt_cell
    import kvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    input  t_commit i_fin,
    output logic    o_tok_valid,
    output t_token  o_tok
);

    logic                        r_valid, n_valid;
    logic                        r_pend, n_pend;
    logic signed [KVT_KEY_W-1:0] r_key, n_key;
    logic signed [KVT_VAL_W-1:0] r_value, n_value;
    logic                        r_tok_valid;
    t_token                      r_tok, n_tok;
    logic                        w_hit;
    logic                        w_take;

    // key match and first free entry for an insert
    assign w_hit  = i_tok_valid && r_valid && (r_key == i_tok.key) && !i_tok.match;
    assign w_take = i_tok_valid && !r_valid && !i_tok.free_seen
                    && (i_tok.opcode == OP_INSERT);

    // outgoing token
    always_comb begin
        n_tok           = i_tok;
        n_tok.any_valid = i_tok.any_valid | r_valid;
        if (w_hit) begin
            n_tok.match = 1'b1;
            if (i_tok.opcode == OP_LOOKUP) begin
                n_tok.rd = r_value;
            end
        end
        if (w_take) begin
            n_tok.free_seen = 1'b1;
        end
    end

    // entry update
    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_key   = r_key;
        n_value = r_value;
        if (w_hit && (i_tok.opcode == OP_REMOVE)) begin
            n_valid = 1'b0;
        end
        if (w_hit && (i_tok.opcode == OP_INSERT)) begin
            n_value = i_tok.value;
        end
        // reserve this entry, kept only if the key is found in no entry of the row
        if (w_take) begin
            n_key   = i_tok.key;
            n_value = i_tok.value;
            n_pend  = 1'b1;
        end
        if (i_fin.valid && r_pend) begin
            n_valid = i_fin.commit;
            n_pend  = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pend      <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_pend      <= n_pend;
            r_tok_valid <= i_tok_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_tok   <= n_tok;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

// ----- sv/key_value_table.sv -----
// ----------------------------------------------------------------------------
// key_value_table
// fixed-capacity associative key value table built as a row of entry cells
// ----------------------------------------------------------------------------
// usage:
//   input beats on s_axis carry an opcode in tuser and key and value in tdata.
//   each beat gives exactly one result beat on m_axis: status and hit in
//   tuser, the looked-up value in tdata.
//   a request walks the cell row one entry per cycle; the result is
//   registered in the output register once the request leaves the last
//   cell, and the next input beat is taken only after that walk through the
//   row has finished, so that the next request sees the table as the
//   previous one left it.
//   reset empties the table at once through the entry valid bits; no
//   clearing pass is needed.
//   when the receiver stalls, one result waits in the output register and a
//   second in a skid register; while the skid register is full, s_axis_tready
//   stays low.
// ----------------------------------------------------------------------------
`include "key_value_table_macros.svh"

module key_value_table
    import kvt_pkg::*;
#(
    parameter int CAPACITY = KVT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] entry_key, [63:32] entry_value
    input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
    // result beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] read_value
    output logic [2:0]  m_axis_tuser   // [1:0] status, [2] hit
);

    logic                        r_busy;
    logic                        w_accept;
    t_token                      w_inj;
    t_commit                     w_fin;
    logic [CAPACITY-1:0]         w_tok_valid;
    t_token                      w_tok [CAPACITY];
    t_token                      w_last;
    logic                        w_exit;
    logic [KVT_ST_W-1:0]         w_status;
    logic                        w_hit;
    logic signed [KVT_VAL_W-1:0] w_rd;

    logic                        r_m_valid, n_m_valid;
    logic [KVT_ST_W-1:0]         r_m_status, n_m_status;
    logic                        r_m_hit, n_m_hit;
    logic signed [KVT_VAL_W-1:0] r_m_rd, n_m_rd;
    logic                        r_skid_valid, n_skid_valid;
    logic [KVT_ST_W-1:0]         r_skid_status, n_skid_status;
    logic                        r_skid_hit, n_skid_hit;
    logic signed [KVT_VAL_W-1:0] r_skid_rd, n_skid_rd;
    logic                        w_out_take;

    // one request in the row at a time
    assign s_axis_tready = !r_busy && !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // fresh token from the input beat
    always_comb begin
        w_inj           = '0;
        w_inj.opcode    = s_axis_tuser[KVT_OP_W-1:0];
        w_inj.key       = s_axis_tdata[KVT_KEY_W-1:0];
        w_inj.value     = s_axis_tdata[KVT_KEY_W+KVT_VAL_W-1:KVT_KEY_W];
    end

    // row of entry cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            kvt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tok_valid (w_accept),
                .i_tok       (w_inj),
                .i_fin       (w_fin),
                .o_tok_valid (w_tok_valid[g]),
                .o_tok       (w_tok[g])
            );
        end else begin : g_body
            kvt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tok_valid (w_tok_valid[g-1]),
                .i_tok       (w_tok[g-1]),
                .i_fin       (w_fin),
                .o_tok_valid (w_tok_valid[g]),
                .o_tok       (w_tok[g])
            );
        end
    end

    assign w_exit = w_tok_valid[CAPACITY-1];
    assign w_last = w_tok[CAPACITY-1];

    // commit a reserved entry only for an insert of an absent key
    assign w_fin.valid  = w_exit;
    assign w_fin.commit = (w_last.opcode == OP_INSERT) && !w_last.match
                          && w_last.free_seen;

    // result of the finished walk
    always_comb begin
        w_status = ST_OK;
        w_hit    = 1'b0;
        w_rd     = w_last.rd;
        case (w_last.opcode)
            OP_INSERT: begin
                if (w_last.match) begin
                    w_hit = 1'b1;
                end else if (!w_last.free_seen) begin
                    w_status = ST_FULL;
                end
            end
            OP_LOOKUP, OP_REMOVE: begin
                if (!w_last.any_valid) begin
                    w_status = ST_EMPTY;
                end else if (!w_last.match) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_hit = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // output register with skid stage
    assign w_out_take = r_m_valid && m_axis_tready;

    always_comb begin
        n_m_valid     = r_m_valid;
        n_m_status    = r_m_status;
        n_m_hit       = r_m_hit;
        n_m_rd        = r_m_rd;
        n_skid_valid  = r_skid_valid;
        n_skid_status = r_skid_status;
        n_skid_hit    = r_skid_hit;
        n_skid_rd     = r_skid_rd;
        if (w_exit) begin
            if (!r_m_valid || w_out_take) begin
                n_m_valid  = 1'b1;
                n_m_status = w_status;
                n_m_hit    = w_hit;
                n_m_rd     = w_rd;
            end else begin
                n_skid_valid  = 1'b1;
                n_skid_status = w_status;
                n_skid_hit    = w_hit;
                n_skid_rd     = w_rd;
            end
        end else if (w_out_take) begin
            n_m_valid    = r_skid_valid;
            n_m_status   = r_skid_status;
            n_m_hit      = r_skid_hit;
            n_m_rd       = r_skid_rd;
            n_skid_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_m_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end
            r_m_valid    <= n_m_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_m_status    <= n_m_status;
        r_m_hit       <= n_m_hit;
        r_m_rd        <= n_m_rd;
        r_skid_status <= n_skid_status;
        r_skid_hit    <= n_skid_hit;
        r_skid_rd     <= n_skid_rd;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_rd;
    assign m_axis_tuser  = {r_m_hit, r_m_status};

    // checks
    `KVT_ASSERT_NOW(a_single_token, i_clk, i_rst_n, 1'b1,
        $countones(w_tok_valid) <= 1, "more than one request in the cell row")
    `KVT_ASSERT_NOW(a_idle_row_empty, i_clk, i_rst_n, !r_busy,
        w_tok_valid == '0, "request in the cell row while idle")
    `KVT_ASSERT_NOW(a_exit_skid_free, i_clk, i_rst_n, w_exit,
        !r_skid_valid, "request finished while the skid register is full")
    `KVT_ASSERT_NOW(a_miss_no_data, i_clk, i_rst_n,
        r_m_valid && (r_m_status != ST_OK),
        !r_m_hit && (r_m_rd == '0), "failed request reports a hit or data")

endmodule

// ----- verif/key_value_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_tb
// self-checking bench for the associative key value table: drives insert,
// lookup, remove and unused-opcode beats with random idling on both stream
// sides, predicts every result from a shadow copy of the table and compares
// each result beat field by field in arrival order
// ----------------------------------------------------------------------------
module key_value_table_tb;
    import kvt_pkg::*;

    // opcode the block must ignore
    localparam logic [KVT_OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [KVT_ST_W-1:0]         status;
        logic                        hit;
        logic signed [KVT_VAL_W-1:0] read_value;
    } t_kv_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // [31:0] entry_key, [63:32] entry_value
    logic [1:0]  s_axis_tuser = '0;  // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // [31:0] read_value
    logic [2:0]  m_axis_tuser;       // [1:0] status, [2] hit

    // shadow copy of the table
    logic [KVT_KEY_W-1:0] shadow_key   [KVT_CAPACITY];
    logic [KVT_VAL_W-1:0] shadow_value [KVT_CAPACITY];
    logic                 shadow_valid [KVT_CAPACITY];

    t_kv_result pending_results[$];
    t_kv_result head_result;
    int         error_count = 0;
    bit         tx_gaps_on = 1'b1;
    bit         rx_stalls_on = 1'b1;
    int         rx_hold_cycles = 0;

    key_value_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // apply one request to the shadow table and return the result it gives
    function automatic t_kv_result table_apply(logic [KVT_OP_W-1:0] op,
                                               logic [KVT_KEY_W-1:0] key,
                                               logic [KVT_VAL_W-1:0] value);
        t_kv_result res;
        int         match_idx;
        int         free_idx;
        bit         occupied;
        res = '0;
        res.status = ST_OK;
        match_idx = -1;
        free_idx = -1;
        occupied = 1'b0;
        for (int i = 0; i < KVT_CAPACITY; i++) begin
            if (shadow_valid[i]) begin
                occupied = 1'b1;
                if (match_idx < 0 && shadow_key[i] == key) match_idx = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        case (op)
            OP_INSERT: begin
                if (match_idx >= 0) begin
                    shadow_value[match_idx] = value;
                    res.hit = 1'b1;
                end else if (free_idx >= 0) begin
                    shadow_key[free_idx] = key;
                    shadow_value[free_idx] = value;
                    shadow_valid[free_idx] = 1'b1;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_LOOKUP, OP_REMOVE: begin
                if (!occupied) begin
                    res.status = ST_EMPTY;
                end else if (match_idx < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.hit = 1'b1;
                    if (op == OP_LOOKUP) res.read_value = shadow_value[match_idx];
                    else shadow_valid[match_idx] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // send one request beat; tvalid stays high on return
    task automatic send_request(input logic [KVT_OP_W-1:0] op,
                                input logic [KVT_KEY_W-1:0] key,
                                input logic [KVT_VAL_W-1:0] value);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {value, key};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(table_apply(op, key, value));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (KVT_CAPACITY + 4) @(posedge i_clk);
    endtask

    // result side: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, status %0d hit %0d value %0h",
                         $time, m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata);
                error_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (m_axis_tuser[1:0] !== head_result.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, head_result.status, m_axis_tuser[1:0]);
                    error_count++;
                end
                if (m_axis_tuser[2] !== head_result.hit) begin
                    $display("%0t: hit mismatch, expected %0d actual %0d",
                             $time, head_result.hit, m_axis_tuser[2]);
                    error_count++;
                end
                if (m_axis_tdata !== head_result.read_value) begin
                    $display("%0t: read_value mismatch, expected %0h actual %0h",
                             $time, head_result.read_value, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // empty table, key extremes, update, misses and the ignored opcode
    task automatic test_directed();
        send_request(OP_LOOKUP, 32'd5, 32'd0);
        send_request(OP_REMOVE, 32'd5, 32'd0);
        send_request(OP_UNUSED, 32'd5, 32'd9);
        send_request(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_INSERT, 32'hffff_ffff, 32'h5a5a_a5a5);
        send_request(OP_INSERT, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
        send_request(OP_LOOKUP, 32'h7fff_ffff, 32'd0);
        send_request(OP_LOOKUP, 32'hffff_ffff, 32'd0);
        send_request(OP_LOOKUP, 32'd1, 32'd0);
        send_request(OP_REMOVE, 32'd1, 32'd0);
        send_request(OP_UNUSED, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(OP_REMOVE, 32'h7fff_ffff, 32'd0);
        send_request(OP_LOOKUP, 32'h7fff_ffff, 32'd0);
        send_request(OP_REMOVE, 32'h8000_0000, 32'd0);
        send_request(OP_REMOVE, 32'h0000_0000, 32'd0);
        send_request(OP_REMOVE, 32'hffff_ffff, 32'd0);
        drain();
    endtask

    // fill past capacity, update and reuse a freed entry while full
    task automatic test_full_table();
        logic [KVT_KEY_W-1:0] fill_keys [KVT_CAPACITY + 2];
        for (int i = 0; i < KVT_CAPACITY + 2; i++) fill_keys[i] = $urandom;
        for (int i = 0; i < KVT_CAPACITY + 2; i++) begin
            send_request(OP_INSERT, fill_keys[i], $urandom);
        end
        send_request(OP_INSERT, fill_keys[0], $urandom);
        send_request(OP_LOOKUP, fill_keys[KVT_CAPACITY + 1], $urandom);
        send_request(OP_REMOVE, fill_keys[3], $urandom);
        send_request(OP_INSERT, fill_keys[KVT_CAPACITY], $urandom);
        send_request(OP_LOOKUP, fill_keys[KVT_CAPACITY], $urandom);
        send_request(OP_LOOKUP, fill_keys[0], $urandom);
        for (int i = 0; i < KVT_CAPACITY + 2; i++) begin
            send_request(OP_REMOVE, fill_keys[i], $urandom);
        end
        send_request(OP_LOOKUP, fill_keys[0], $urandom);
        drain();
    endtask

    // traffic over a small key set so that hits, full and empty all occur
    task automatic test_pool_traffic(input int count, input int pool_size,
                                     input int insert_pct);
        logic [KVT_KEY_W-1:0] key_pool [32];
        logic [KVT_OP_W-1:0]  op;
        logic [KVT_KEY_W-1:0] key;
        int                   pick;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 32; i++) key_pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
                op = OP_INSERT;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0) op = OP_UNUSED;
                else if (pick < 10) op = OP_LOOKUP;
                else op = OP_REMOVE;
            end
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request(op, key, $urandom);
        end
        drain();
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        for (int n = 0; n < 12; n++) begin
            send_request(n % 2 ? OP_LOOKUP : OP_INSERT, n / 2, $urandom);
        end
        drain();
    endtask

    // fully random beats, mostly misses
    task automatic test_random_keys(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(KVT_OP_W'($urandom_range(0, 3)), $urandom, $urandom);
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < KVT_CAPACITY; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_pool_traffic(500, 24, 50);
        test_backpressure();
        // back to back, no idling on either side
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        test_pool_traffic(300, 20, 45);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        test_pool_traffic(300, 12, 30);
        test_random_keys(100);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/kvt_pkg.sv
sv/kvt_cell.sv
sv/key_value_table.sv
verif/key_value_table_tb.sv
